FILE: hdl/rgb_to_yuv420_stream_defines.svh
// Assertion macros for the port-level checker of the RGB to YUV 4:2:0 converter.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef RGB_TO_YUV420_STREAM_DEFINES_SVH
`define RGB_TO_YUV420_STREAM_DEFINES_SVH

// The consequent is checked in the same cycle as the antecedent.
`define RTYV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtyv checker: same-cycle property failed");

// The consequent is checked in the cycle after the antecedent.
`define RTYV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtyv checker: next-cycle property failed");

`endif

FILE: hdl/rtyv_pkg.sv
// Shared types and constants of the RGB to YUV 4:2:0 converter.
// Used by the front end, the queue wiring, the back end and the top level.
`default_nettype none

package rtyv_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int ROW_CMP_W  = 14;

  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // BT.601 integer coefficients, all scaled by 1000.
  localparam logic [9:0] Y_R_COEF  = 10'd299;
  localparam logic [9:0] Y_G_COEF  = 10'd587;
  localparam logic [9:0] Y_B_COEF  = 10'd114;
  localparam logic [9:0] CB_R_COEF = 10'd169;
  localparam logic [9:0] CB_G_COEF = 10'd331;
  localparam logic [9:0] C_MAIN_COEF = 10'd500;
  localparam logic [9:0] CR_G_COEF = 10'd419;
  localparam logic [9:0] CR_B_COEF = 10'd81;
  localparam logic [7:0] CHROMA_BIAS = 8'd128;

  // ceil(2^28 / 1000): exact floor division by 1000 for any 18-bit numerator.
  localparam logic [18:0] RECIP_1000  = 19'd268436;
  localparam int          RECIP_SHIFT = 28;

  localparam int SUM_W  = 9;
  localparam int LINE_W = 2 * SUM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic frame_last;
    logic row_odd;
    logic col_odd;
  } pix_tag_t;

endpackage

`default_nettype wire

FILE: hdl/rtyv_front.sv
// Front end: configuration registers, raster position counters and pixel tagging.
// Depends on rtyv_pkg.
`default_nettype none

module rtyv_front
  import rtyv_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 queue_full_i,
  input  wire rgb_t                 pix_i,
  output logic                      push_o,
  output rgb_t                      push_pix_o,
  output pix_tag_t                  push_tag_o,
  output logic [((((MAX_WIDTH + 1) / 2) > 1) ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0]
                                    push_idx_o
);

  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W      = (COL_W + 1 > CFG_W + 1) ? COL_W + 1 : CFG_W + 1;

  logic [CFG_W-1:0]     width_q, height_q;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [CMP_W-1:0]     col_nxt;
  logic [ROW_CMP_W-1:0] row_nxt;
  logic                 row_end, frame_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero size compares like one; an oversize one is capped by the second compare.
  always_comb begin
    col_nxt    = CMP_W'(col_q) + CMP_W'(1);
    row_nxt    = ROW_CMP_W'(row_q) + ROW_CMP_W'(1);
    row_end    = (col_nxt >= CMP_W'(width_q)) || (col_nxt >= CMP_W'(MAX_WIDTH));
    frame_last = row_end && ((row_nxt >= ROW_CMP_W'(height_q)) ||
                             (row_nxt >= ROW_CMP_W'(MAX_HEIGHT)));
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_last ? '0 : row_nxt[ROW_W-1:0];
      end else begin
        col_d = col_nxt[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o                = in_valid_i && !queue_full_i;
  assign push_pix_o            = pix_i;
  assign push_tag_o.frame_last = frame_last;
  assign push_tag_o.row_odd    = row_q[0];
  assign push_tag_o.col_odd    = col_q[0];
  assign push_idx_o            = col_q[PAIR_AW:1];

endmodule

`default_nettype wire

FILE: hdl/rtyv_queue.sv
// Short first-in first-out queue that decouples the front end from the back end.
// Depends on rtyv_pkg for its depth and pointer widths.
`default_nettype none

module rtyv_queue
  import rtyv_pkg::*;
#(
  parameter int DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] push_data_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               valid_o,
  output logic [DW-1:0]      data_o
);

  logic [DW-1:0]     slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      priority if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end else begin
        cnt_q <= cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: hdl/rtyv_back.sv
// Back end: colour conversion pipeline, 2x2 chroma accumulation with the line store,
// and the output register. Depends on rtyv_pkg.
`default_nettype none

module rtyv_back
  import rtyv_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_valid_i,
  input  wire rgb_t     q_pix_i,
  input  wire pix_tag_t q_tag_i,
  input  wire logic [((((MAX_WIDTH + 1) / 2) > 1) ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0]
                        q_idx_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output logic [7:0]    luma_o,
  output logic          chroma_valid_o,
  output logic [7:0]    blue_diff_o,
  output logic [7:0]    red_diff_o,
  output logic          frame_end_o
);

  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int NUM_W      = 18;
  localparam int PROD_W     = NUM_W + 19;

  function automatic logic [7:0] div_by_1000(input logic [NUM_W-1:0] num);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(num) * PROD_W'(RECIP_1000);
    return prod[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

  logic en;
  logic v1_q, v2_q, v3_q, out_valid_q;

  // Stage 1: numerators as magnitude and sign.
  logic [NUM_W-1:0]   y_num, cb_pos, cb_negp, cr_pos, cr_negp, cb_mag, cr_mag;
  logic               cb_neg, cr_neg;
  logic [NUM_W-1:0]   y_num_q, cb_mag_q, cr_mag_q;
  logic               cb_neg_q, cr_neg_q;
  pix_tag_t           tag1_q;
  logic [PAIR_AW-1:0] idx1_q;

  // Stage 2: per-pixel Y, Cb and Cr.
  logic [7:0]         y_q2_q, cb2_q, cr2_q, cb_quo, cr_quo;
  pix_tag_t           tag2_q;
  logic [PAIR_AW-1:0] idx2_q;

  // Stage 3: pair sums and line store access.
  logic [7:0]         hold_cb_q, hold_cr_q;
  logic [SUM_W-1:0]   scb, scr, scb3_q, scr3_q;
  logic               line_we;
  logic [LINE_W-1:0]  line_mem [PAIR_DEPTH];
  logic [LINE_W-1:0]  line_rd_q;
  logic [7:0]         y3_q;
  logic               chroma3_q, last3_q;

  // Output stage.
  logic [SUM_W:0]     tcb, tcr;
  logic [7:0]         luma_q, blue_q, red_q;
  logic               chroma_q, last_q;

  assign en      = !out_valid_q || !out_stall_i;
  assign q_pop_o = en && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= q_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_comb begin
    y_num   = NUM_W'(q_pix_i.red) * NUM_W'(Y_R_COEF) + NUM_W'(q_pix_i.green) * NUM_W'(Y_G_COEF)
            + NUM_W'(q_pix_i.blue) * NUM_W'(Y_B_COEF);
    cb_pos  = NUM_W'(q_pix_i.blue) * NUM_W'(C_MAIN_COEF);
    cb_negp = NUM_W'(q_pix_i.red) * NUM_W'(CB_R_COEF)
            + NUM_W'(q_pix_i.green) * NUM_W'(CB_G_COEF);
    cr_pos  = NUM_W'(q_pix_i.red) * NUM_W'(C_MAIN_COEF);
    cr_negp = NUM_W'(q_pix_i.green) * NUM_W'(CR_G_COEF)
            + NUM_W'(q_pix_i.blue) * NUM_W'(CR_B_COEF);
    cb_neg  = cb_negp > cb_pos;
    cr_neg  = cr_negp > cr_pos;
    cb_mag  = cb_neg ? cb_negp - cb_pos : cb_pos - cb_negp;
    cr_mag  = cr_neg ? cr_negp - cr_pos : cr_pos - cr_negp;
  end

  // Truncation toward zero: divide the magnitude, then apply the sign around the bias.
  assign cb_quo = div_by_1000(cb_mag_q);
  assign cr_quo = div_by_1000(cr_mag_q);

  always_comb begin
    scb     = SUM_W'(hold_cb_q) + SUM_W'(cb2_q);
    scr     = SUM_W'(hold_cr_q) + SUM_W'(cr2_q);
    line_we = v2_q && tag2_q.col_odd && !tag2_q.row_odd;
    tcb     = (SUM_W + 1)'(line_rd_q[LINE_W-1:SUM_W]) + (SUM_W + 1)'(scb3_q);
    tcr     = (SUM_W + 1)'(line_rd_q[SUM_W-1:0]) + (SUM_W + 1)'(scr3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_num_q  <= y_num;
      cb_mag_q <= cb_mag;
      cr_mag_q <= cr_mag;
      cb_neg_q <= cb_neg;
      cr_neg_q <= cr_neg;
      tag1_q   <= q_tag_i;
      idx1_q   <= q_idx_i;

      y_q2_q <= div_by_1000(y_num_q);
      cb2_q  <= cb_neg_q ? CHROMA_BIAS - cb_quo : CHROMA_BIAS + cb_quo;
      cr2_q  <= cr_neg_q ? CHROMA_BIAS - cr_quo : CHROMA_BIAS + cr_quo;
      tag2_q <= tag1_q;
      idx2_q <= idx1_q;

      if (v2_q && !tag2_q.col_odd) begin
        hold_cb_q <= cb2_q;
        hold_cr_q <= cr2_q;
      end
      y3_q      <= y_q2_q;
      scb3_q    <= scb;
      scr3_q    <= scr;
      chroma3_q <= tag2_q.col_odd && tag2_q.row_odd;
      last3_q   <= tag2_q.frame_last;

      luma_q   <= y3_q;
      chroma_q <= chroma3_q;
      blue_q   <= chroma3_q ? tcb[SUM_W:2] : 8'd0;
      red_q    <= chroma3_q ? tcr[SUM_W:2] : 8'd0;
      last_q   <= last3_q;
    end
  end

  // Even rows write pair sums; odd rows read them back two or more pixels later.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (line_we) line_mem[idx2_q] <= {scb, scr};
      line_rd_q <= line_mem[idx2_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign luma_o         = luma_q;
  assign chroma_valid_o = chroma_q;
  assign blue_diff_o    = blue_q;
  assign red_diff_o     = red_q;
  assign frame_end_o    = last_q;

endmodule

`default_nettype wire

FILE: hdl/rgb_to_yuv420_stream.sv
// Throughput: one pixel per cycle unless out_stall_i holds the output, set by
// the fully pipelined back end and the single read/write port of the line store
// used once per pixel.
// Reset (rst_ni low, asynchronous): counters, queue and valid flags clear and the frame
// size returns to 640 x 480; the line store is not cleared, so no clearing pass is needed.
`default_nettype none

module rgb_to_yuv420_stream
  import rtyv_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           red_i,
  input  wire logic [7:0]           green_i,
  input  wire logic [7:0]           blue_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                luma_o,
  output logic                      chroma_valid_o,
  output logic [7:0]                blue_diff_o,
  output logic [7:0]                red_diff_o,
  output logic                      frame_end_o
);

  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int QDW        = $bits(rgb_t) + $bits(pix_tag_t) + PAIR_AW;

  rgb_t               in_pix, push_pix, q_pix;
  pix_tag_t           push_tag, q_tag;
  logic [PAIR_AW-1:0] push_idx, q_idx;
  logic               push, q_full, q_valid, q_pop;
  logic [QDW-1:0]     q_data;

  assign in_pix.red   = red_i;
  assign in_pix.green = green_i;
  assign in_pix.blue  = blue_i;
  assign in_stall_o   = q_full;

  rtyv_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .queue_full_i (q_full),
    .pix_i        (in_pix),
    .push_o       (push),
    .push_pix_o   (push_pix),
    .push_tag_o   (push_tag),
    .push_idx_o   (push_idx)
  );

  rtyv_queue #(
    .DW (QDW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_pix, push_tag, push_idx}),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  assign {q_pix, q_tag, q_idx} = q_data;

  rtyv_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pix_i        (q_pix),
    .q_tag_i        (q_tag),
    .q_idx_i        (q_idx),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .luma_o         (luma_o),
    .chroma_valid_o (chroma_valid_o),
    .blue_diff_o    (blue_diff_o),
    .red_diff_o     (red_diff_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

`default_nettype wire

FILE: hdl/rtyv_checker.sv
// Port-level checker for the RGB to YUV 4:2:0 converter, bound to the top level.
// Depends on rgb_to_yuv420_stream_defines.svh.
`default_nettype none
`include "rgb_to_yuv420_stream_defines.svh"

module rtyv_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] luma_o,
  input wire logic       chroma_valid_o,
  input wire logic [7:0] blue_diff_o,
  input wire logic [7:0] red_diff_o,
  input wire logic       frame_end_o
);

  // A result that waits must be offered unchanged in the next cycle.
  `RTYV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(luma_o) && $stable(chroma_valid_o) && $stable(blue_diff_o) && $stable(red_diff_o) && $stable(frame_end_o))

  // Pixels that complete no block carry zero chroma.
  `RTYV_ASSERT_SAME(a_no_chroma_zero, out_valid_o && !chroma_valid_o, blue_diff_o == 8'd0 && red_diff_o == 8'd0)

  // Each per-pixel chroma value is at least one, so a block average never reaches zero.
  `RTYV_ASSERT_SAME(a_chroma_nonzero, out_valid_o && chroma_valid_o, blue_diff_o != 8'd0 && red_diff_o != 8'd0)

  // Blocks close on odd columns only, so two transferred results in a row never both do.
  `RTYV_ASSERT_SAME(a_chroma_alternate, (out_valid_o && !out_stall_i && chroma_valid_o) ##1 out_valid_o, !chroma_valid_o)

endmodule

bind rgb_to_yuv420_stream rtyv_checker u_checker (.*);

`default_nettype wire

FILE: tb/rgb_to_yuv420_stream_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the RGB to YUV 4:2:0 converter: follows frame size writes and
// pixel transfers, predicts every result and compares it with the output channel.
// Depends on rtyv_pkg only.
module rgb_to_yuv420_stream_checker
  import rtyv_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [7:0]           luma_i,
  input  logic                 chroma_valid_i,
  input  logic [7:0]           blue_diff_i,
  input  logic [7:0]           red_diff_i,
  input  logic                 frame_end_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic       frame_end;
  } yuv_result_t;

  int frame_width;
  int frame_height;
  int column_at;
  int row_at;
  int held_cb;
  int held_cr;
  int error_count = 0;
  logic [17:0] pair_sums [PAIR_DEPTH];
  yuv_result_t expected_yuv [$];

  function automatic int clamp_size(input int size, input int limit);
    if (size == 0) return 1;
    if (size > limit) return limit;
    return size;
  endfunction

  // Converts one pixel and advances the raster position.
  function automatic yuv_result_t convert_pixel(input logic [7:0] r8, g8, b8);
    int r, g, b, w, h, cb, cr, idx, sum_cb, sum_cr;
    yuv_result_t res;
    r = r8;
    g = g8;
    b = b8;
    w = clamp_size(frame_width, MAX_WIDTH);
    h = clamp_size(frame_height, MAX_HEIGHT);
    res = '0;
    res.luma = 8'((r * 299 + g * 587 + b * 114) / 1000);
    // Integer division truncates toward zero, as the chroma terms require.
    cb = (-r * 169 - g * 331 + b * 500) / 1000 + 128;
    cr = (r * 500 - g * 419 - b * 81) / 1000 + 128;
    if (column_at % 2 == 0) begin
      held_cb = cb;
      held_cr = cr;
    end else begin
      idx = column_at / 2;
      sum_cb = held_cb + cb;
      sum_cr = held_cr + cr;
      if (idx < PAIR_DEPTH) begin
        if (row_at % 2 == 0) begin
          pair_sums[idx] = {9'(sum_cb), 9'(sum_cr)};
        end else begin
          sum_cb = sum_cb + int'(pair_sums[idx][17:9]);
          sum_cr = sum_cr + int'(pair_sums[idx][8:0]);
          res.chroma_valid = 1'b1;
          res.blue_diff = 8'(sum_cb / 4);
          res.red_diff = 8'(sum_cr / 4);
        end
      end
    end
    // A counter at or past the last position ends the row, and perhaps the frame.
    if (column_at + 1 >= w) begin
      res.frame_end = (row_at + 1 >= h);
      column_at = 0;
      row_at = res.frame_end ? 0 : row_at + 1;
    end else begin
      column_at++;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    yuv_result_t want;
    if (!rst_ni) begin
      frame_width = FRAME_WIDTH_RST;
      frame_height = FRAME_HEIGHT_RST;
      column_at = 0;
      row_at = 0;
      held_cb = 0;
      held_cr = 0;
      expected_yuv.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_FRAME_WIDTH) frame_width = cfg_data_i;
        else frame_height = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_yuv.push_back(convert_pixel(red_i, green_i, blue_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_yuv.size() == 0) begin
          $error("result transfer with no pixel outstanding");
          error_count++;
        end else begin
          want = expected_yuv.pop_front();
          check_field("luma", want.luma, luma_i);
          check_field("chroma_valid", want.chroma_valid, chroma_valid_i);
          check_field("blue_diff", want.blue_diff, blue_diff_i);
          check_field("red_diff", want.red_diff, red_diff_i);
          check_field("frame_end", want.frame_end, frame_end_i);
        end
      end
      pending_o <= expected_yuv.size();
      errors_o <= error_count;
    end
  end

endmodule

FILE: tb/rgb_to_yuv420_stream_tb.sv
`timescale 1ns / 100ps
// Testbench top for the RGB to YUV 4:2:0 converter: clock, reset, pixel and
// back-pressure stimulus, frame size changes and the final verdict.
// Depends on rtyv_pkg, rgb_to_yuv420_stream and rgb_to_yuv420_stream_checker.
module rgb_to_yuv420_stream_tb;
  import rtyv_pkg::*;

  localparam int RANDOM_PIXELS = 1780;
  localparam int FILL_COLS     = 128;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  cfg_reg_e         cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       red = '0;
  logic [7:0]       green = '0;
  logic [7:0]       blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       luma;
  logic             chroma_valid;
  logic [7:0]       blue_diff;
  logic [7:0]       red_diff;
  logic             frame_end;
  logic             quiet = 1'b0;
  int               stall_left = 0;
  int               errors;
  int               pending;
  int               col_at = 0;
  int               width_eff = 640;

  // Primaries, secondaries and grey extremes, the chroma corners, plus one other colour.
  logic [23:0] corner_px [0:14] = '{
    24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h807F01,
    24'h0000FF, 24'h0000FF, 24'hFF0000, 24'hFF0000,
    24'hFFFFFF, 24'h000000
  };

  always #5 clk = ~clk;

  rgb_to_yuv420_stream DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .luma_o         (luma),
    .chroma_valid_o (chroma_valid),
    .blue_diff_o    (blue_diff),
    .red_diff_o     (red_diff),
    .frame_end_o    (frame_end)
  );

  rgb_to_yuv420_stream_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .luma_i         (luma),
    .chroma_valid_i (chroma_valid),
    .blue_diff_i    (blue_diff),
    .red_diff_i     (red_diff),
    .frame_end_i    (frame_end),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  function automatic int pick_idle();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Frame dimensions: mostly small so that whole frames fit in a phase.
  function automatic int pick_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 0;
    if (roll < 80) return $urandom_range(1, 8);
    if (roll < 95) return $urandom_range(9, 40);
    return $urandom_range(4000, 8191);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 15) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(7, 23) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a rising edge; returns at the edge on which the transfer happens.
  // The column position is followed here so that wide frames stay inside the
  // primed part of the line store.
  task automatic push_pixel(input logic [7:0] r, g, b);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (in_stall);
    if (col_at + 1 >= width_eff) col_at = 0;
    else col_at++;
  endtask

  task automatic push_noise(input int count);
    repeat (count) push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
  endtask

  task automatic push_corners(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      push_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
    end
  endtask

  // The count of outstanding results is registered, so it lags behind the last transfer.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_size(input int w, input int h);
    width_eff = (w == 0) ? 1 : w;
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int sent, w, h, n, frame_px;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One full even row primes the first line store entries, so later odd
    // rows never read locations that were never written.
    write_size(FILL_COLS, 1);
    push_noise(FILL_COLS);
    drain();

    write_size(3, 3);
    push_corners(0, 8);
    drain();
    write_size(2, 2);
    push_corners(9, 12);
    drain();
    write_size(0, 0);
    push_corners(13, 14);
    drain();
    // Zero width acts as one column; the tallest height clamps to the maximum.
    write_size(0, 8191);
    push_noise(16);
    drain();
    // Shrink in mid-frame: the row counter, and later the column counter, end
    // up past the new last position.
    write_size(6, 4);
    push_noise(9);
    drain();
    write_size(2, 2);
    push_noise(3);

    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      w = pick_dim();
      h = pick_dim();
      drain();
      quiet <= ($urandom_range(0, 3) == 0);
      write_size(w, h);
      frame_px = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      if (frame_px <= 200) begin
        n = frame_px * $urandom_range(1, 3) + $urandom_range(0, 3);
      end else begin
        n = $urandom_range(1, 200);
      end
      if (w > FILL_COLS && n > FILL_COLS - 1 - col_at) begin
        n = FILL_COLS - 1 - col_at;
      end
      push_noise(n);
      sent += n;
    end
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("rgb_to_yuv420_stream_tb: PASS");
    end else begin
      $display("rgb_to_yuv420_stream_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("rgb_to_yuv420_stream_tb: FAIL");
    $finish;
  end

endmodule
